// ----- hdl/edid_base_block_field_parser_defines.svh -----
// ---------------------------------------------------------------------------
// EDID base block field parser: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef EDID_BASE_BLOCK_FIELD_PARSER_DEFINES_SVH
`define EDID_BASE_BLOCK_FIELD_PARSER_DEFINES_SVH

// same-cycle implication
`define EBBFP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EBBFP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ebbfp_pkg.sv -----
// ---------------------------------------------------------------------------
// EDID base block field parser package
// Record kinds, byte offsets and descriptor tags.
// ---------------------------------------------------------------------------
package ebbfp_pkg;

    typedef enum logic [3:0] {
        KIND_HDR_ERR    = 4'd0,
        KIND_SHORT      = 4'd1,
        KIND_VENDOR     = 4'd2,
        KIND_SERIAL     = 4'd3,
        KIND_SIZE       = 4'd4,
        KIND_CHROMA     = 4'd5,
        KIND_NAME_CHAR  = 4'd6,
        KIND_SER_CHAR   = 4'd7,
        KIND_TEXT_CHAR  = 4'd8,
        KIND_DONE       = 4'd9
    } kind_t;

    localparam int IDX_W = 7;

    localparam logic [IDX_W-1:0] HDR_OFS0       = 7'd0;
    localparam logic [IDX_W-1:0] HDR_OFS1       = 7'd1;
    localparam logic [IDX_W-1:0] VENDOR_OFS     = 7'd8;
    localparam logic [IDX_W-1:0] VENDOR_OFS2    = 7'd9;
    localparam logic [IDX_W-1:0] SERIAL_OFS     = 7'd12;
    localparam logic [IDX_W-1:0] SERIAL_LAST    = 7'd15;
    localparam logic [IDX_W-1:0] SIZE_OFS       = 7'd21;
    localparam logic [IDX_W-1:0] SIZE_OFS2      = 7'd22;
    localparam logic [IDX_W-1:0] GAMMA_OFS      = 7'd23;
    localparam logic [IDX_W-1:0] CHROMA_LO_OFS  = 7'd25;
    localparam logic [IDX_W-1:0] CHROMA_HI_OFS  = 7'd26;
    localparam logic [IDX_W-1:0] CHROMA_OFS     = 7'd27;
    localparam logic [IDX_W-1:0] CHROMA_LAST    = 7'd34;
    localparam logic [IDX_W-1:0] DESC_PRE       = 7'd53;   // 0x36 - 1
    localparam logic [IDX_W-1:0] DESC_FIRST     = 7'd54;   // 0x36
    localparam logic [IDX_W-1:0] DESC_END       = 7'd125;  // 0x6c + 18 - 1
    localparam logic [IDX_W-1:0] LAST_INDEX     = 7'd127;

    localparam logic [4:0] DESC_LAST_OFF = 5'd17;
    localparam logic [4:0] DOFF_USABLE   = 5'd0;
    localparam logic [4:0] DOFF_CHECK    = 5'd2;
    localparam logic [4:0] DOFF_TAG      = 5'd3;
    localparam logic [4:0] DOFF_CHAR0    = 5'd5;
    localparam logic [4:0] DOFF_CHARN    = 5'd16;
    localparam logic [4:0] DOFF_GAMMA_A  = 5'd12;
    localparam logic [4:0] DOFF_GAMMA_B  = 5'd17;

    localparam logic [7:0] TAG_NAME   = 8'hfc;
    localparam logic [7:0] TAG_SERIAL = 8'hff;
    localparam logic [7:0] TAG_TEXT   = 8'hfe;
    localparam logic [7:0] TAG_CPOINT = 8'hfb;

    localparam logic [7:0] HDR_BYTE1  = 8'hff;
    localparam logic [7:0] GAMMA_NONE = 8'hff;
    localparam logic [8:0] GAMMA_BASE = 9'd100;

endpackage

// ----- hdl/ebbfp_if.sv -----
// ---------------------------------------------------------------------------
// EDID base block field parser channels
// Byte stream in and field record stream out, valid/ready handshake.
// ---------------------------------------------------------------------------
interface ebbfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] edid_byte;
    logic       final_byte;

    modport source (output valid, output edid_byte, output final_byte, input ready);
    modport sink   (input valid, input edid_byte, input final_byte, output ready);
endinterface

interface ebbfp_rec_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [31:0] value;
    logic [7:0]  second_value;
    logic [3:0]  position;
    logic [1:0]  descriptor_slot;

    modport source (output valid, output kind, output value, output second_value,
                    output position, output descriptor_slot, input ready);
    modport sink   (input valid, input kind, input value, input second_value,
                    input position, input descriptor_slot, output ready);
endinterface

// ----- hdl/edid_base_block_field_parser.sv -----
// ---------------------------------------------------------------------------
// EDID base block field parser
// Turns an EDID byte stream into tagged field records.
// ---------------------------------------------------------------------------
// One byte word is taken per clock whenever the record register is empty or
// is being drained in the same cycle, so the block sustains one word per
// cycle; a record appears on the output in the cycle after the byte that
// completes it. Each byte is decoded in a single combinational pass against
// the running byte index (header check, vendor letters, serial, size, gamma,
// chroma, four 18-byte descriptors) and at most one record results. A short
// stream (final_byte before byte 127) yields only a short block record; a bad
// header yields a header error record. After an error or the done record at
// byte 127 (which carries gamma x 100), bytes are swallowed until final_byte,
// and every final_byte word returns the parser to its reset state.
// ---------------------------------------------------------------------------
module edid_base_block_field_parser (
    input  logic               clk,
    input  logic               rst_n,
    ebbfp_byte_if.sink         stream,
    ebbfp_rec_if.source        records
);

    localparam int IW = ebbfp_pkg::IDX_W;

    // parser state
    logic [IW-1:0] idx_reg,       idx_next;
    logic          hdr_good_reg,  hdr_good_next;
    logic          finished_reg,  finished_next;
    logic [23:0]   held_reg,      held_next;
    logic [15:0]   chroma_lo_reg, chroma_lo_next;
    logic          usable_reg,    usable_next;
    logic [7:0]    tag_reg,       tag_next;
    logic [8:0]    gamma_reg,     gamma_next;
    logic [4:0]    doff_reg,      doff_next;    // offset inside current descriptor
    logic [1:0]    dslot_reg,     dslot_next;   // descriptor number

    // record register
    logic          out_valid_reg, out_valid_next;
    logic [3:0]    kind_reg;
    logic [31:0]   value_reg;
    logic [7:0]    second_reg;
    logic [3:0]    pos_reg;
    logic [1:0]    slot_reg;

    // record from this word
    logic          res_valid;
    ebbfp_pkg::kind_t res_kind;
    logic [31:0]   res_value;
    logic [7:0]    res_second;
    logic [3:0]    res_pos;
    logic [1:0]    res_slot;

    logic          accept;
    logic [7:0]    b;
    logic          fin;
    logic [2:0]    ck;
    logic [7:0]    csrc;
    logic [1:0]    clo;
    logic [7:0]    vh;

    assign stream.ready = !out_valid_reg || records.ready;
    assign accept       = stream.valid && stream.ready;
    assign b            = stream.edid_byte;
    assign fin          = stream.final_byte;

    // chroma: index within the eight coordinates, low bits come from 0x19/0x1a
    assign ck   = 3'(idx_reg - ebbfp_pkg::CHROMA_OFS);
    assign csrc = ck[2] ? chroma_lo_reg[15:8] : chroma_lo_reg[7:0];
    always_comb
    begin
        case (ck[1:0])
            2'd0:    clo = csrc[7:6];
            2'd1:    clo = csrc[5:4];
            2'd2:    clo = csrc[3:2];
            default: clo = csrc[1:0];
        endcase
    end

    assign vh = held_reg[7:0];

    always_comb
    begin
        idx_next       = idx_reg;
        hdr_good_next  = hdr_good_reg;
        finished_next  = finished_reg;
        held_next      = held_reg;
        chroma_lo_next = chroma_lo_reg;
        usable_next    = usable_reg;
        tag_next       = tag_reg;
        gamma_next     = gamma_reg;
        doff_next      = doff_reg;
        dslot_next     = dslot_reg;

        res_valid  = 1'b0;
        res_kind   = ebbfp_pkg::KIND_HDR_ERR;
        res_value  = '0;
        res_second = '0;
        res_pos    = '0;
        res_slot   = '0;

        if (accept && !finished_reg)
        begin
            if (fin && idx_reg != ebbfp_pkg::LAST_INDEX)
            begin
                // short block beats any other record of this byte
                res_valid = 1'b1;
                res_kind  = ebbfp_pkg::KIND_SHORT;
            end
            else
            begin
                if (idx_reg == ebbfp_pkg::HDR_OFS0)
                begin
                    hdr_good_next = (b == 8'h00);
                end
                else if (idx_reg == ebbfp_pkg::HDR_OFS1)
                begin
                    if (!(hdr_good_reg && b == ebbfp_pkg::HDR_BYTE1))
                    begin
                        res_valid     = 1'b1;
                        res_kind      = ebbfp_pkg::KIND_HDR_ERR;
                        finished_next = 1'b1;
                    end
                end
                else if (idx_reg == ebbfp_pkg::VENDOR_OFS || idx_reg == ebbfp_pkg::SIZE_OFS ||
                         (idx_reg >= ebbfp_pkg::SERIAL_OFS &&
                          idx_reg < ebbfp_pkg::SERIAL_LAST))
                begin
                    held_next = {held_reg[15:0], b};
                end
                else if (idx_reg == ebbfp_pkg::VENDOR_OFS2)
                begin
                    // 5-bit letters, 1 = 'A'; adding 0x40 is a prefix of 010
                    res_valid = 1'b1;
                    res_kind  = ebbfp_pkg::KIND_VENDOR;
                    res_value = {8'h00, 3'b010, vh[6:2], 3'b010, vh[1:0], b[7:5],
                                 3'b010, b[4:0]};
                end
                else if (idx_reg == ebbfp_pkg::SERIAL_LAST)
                begin
                    res_valid = 1'b1;
                    res_kind  = ebbfp_pkg::KIND_SERIAL;
                    res_value = {b, held_reg[7:0], held_reg[15:8], held_reg[23:16]};
                end
                else if (idx_reg == ebbfp_pkg::SIZE_OFS2)
                begin
                    res_valid = 1'b1;
                    res_kind  = ebbfp_pkg::KIND_SIZE;
                    if (vh != 8'h00 && b != 8'h00)
                    begin
                        res_value  = {24'h0, vh};
                        res_second = b;
                    end
                end
                else if (idx_reg == ebbfp_pkg::GAMMA_OFS)
                begin
                    gamma_next = (b == ebbfp_pkg::GAMMA_NONE) ? ebbfp_pkg::GAMMA_BASE
                                                               : {1'b0, b} + ebbfp_pkg::GAMMA_BASE;
                end
                else if (idx_reg == ebbfp_pkg::CHROMA_LO_OFS)
                begin
                    chroma_lo_next[7:0] = b;
                end
                else if (idx_reg == ebbfp_pkg::CHROMA_HI_OFS)
                begin
                    chroma_lo_next[15:8] = b;
                end
                else if (idx_reg >= ebbfp_pkg::CHROMA_OFS && idx_reg <= ebbfp_pkg::CHROMA_LAST)
                begin
                    res_valid = 1'b1;
                    res_kind  = ebbfp_pkg::KIND_CHROMA;
                    res_value = {22'h0, b, clo};
                    res_pos   = {1'b0, ck};
                end
                else if (idx_reg >= ebbfp_pkg::DESC_FIRST && idx_reg <= ebbfp_pkg::DESC_END)
                begin
                    if (doff_reg == ebbfp_pkg::DOFF_USABLE)
                    begin
                        usable_next = (b == 8'h00);
                    end
                    else if (doff_reg == ebbfp_pkg::DOFF_CHECK)
                    begin
                        if (b != 8'h00)
                        begin
                            usable_next = 1'b0;
                        end
                    end
                    else if (doff_reg == ebbfp_pkg::DOFF_TAG)
                    begin
                        tag_next = b;
                    end
                    else if (doff_reg >= ebbfp_pkg::DOFF_CHAR0 &&
                             doff_reg <= ebbfp_pkg::DOFF_CHARN && usable_reg)
                    begin
                        res_value = {24'h0, b};
                        res_pos   = 4'(doff_reg - ebbfp_pkg::DOFF_CHAR0);
                        res_slot  = dslot_reg;
                        if (tag_reg == ebbfp_pkg::TAG_NAME)
                        begin
                            res_valid = 1'b1;
                            res_kind  = ebbfp_pkg::KIND_NAME_CHAR;
                        end
                        else if (tag_reg == ebbfp_pkg::TAG_SERIAL)
                        begin
                            res_valid = 1'b1;
                            res_kind  = ebbfp_pkg::KIND_SER_CHAR;
                        end
                        else if (tag_reg == ebbfp_pkg::TAG_TEXT)
                        begin
                            res_valid = 1'b1;
                            res_kind  = ebbfp_pkg::KIND_TEXT_CHAR;
                        end
                    end
                    // colour-point descriptor carries two gamma bytes
                    if ((doff_reg == ebbfp_pkg::DOFF_GAMMA_A ||
                         doff_reg == ebbfp_pkg::DOFF_GAMMA_B) &&
                        usable_reg && tag_reg == ebbfp_pkg::TAG_CPOINT &&
                        b != ebbfp_pkg::GAMMA_NONE)
                    begin
                        gamma_next = {1'b0, b} + ebbfp_pkg::GAMMA_BASE;
                    end
                end
                else if (idx_reg == ebbfp_pkg::LAST_INDEX)
                begin
                    res_valid     = 1'b1;
                    res_kind      = ebbfp_pkg::KIND_DONE;
                    res_value     = {23'h0, gamma_reg};
                    finished_next = 1'b1;
                end

                // advance index and descriptor position
                if (!finished_next && idx_reg != ebbfp_pkg::LAST_INDEX)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == ebbfp_pkg::DESC_PRE)
                    begin
                        doff_next  = '0;
                        dslot_next = '0;
                    end
                    else if (doff_reg == ebbfp_pkg::DESC_LAST_OFF)
                    begin
                        doff_next  = '0;
                        dslot_next = dslot_reg + 1'b1;
                    end
                    else
                    begin
                        doff_next = doff_reg + 1'b1;
                    end
                end
            end
        end

        // last word of the stream: back to reset state
        if (accept && fin)
        begin
            idx_next       = '0;
            hdr_good_next  = 1'b1;
            finished_next  = 1'b0;
            held_next      = '0;
            chroma_lo_next = '0;
            usable_next    = 1'b0;
            tag_next       = '0;
            gamma_next     = ebbfp_pkg::GAMMA_BASE;
            doff_next      = '0;
            dslot_next     = '0;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = res_valid;
        end
        else if (records.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            hdr_good_reg  <= 1'b1;
            finished_reg  <= 1'b0;
            held_reg      <= '0;
            chroma_lo_reg <= '0;
            usable_reg    <= 1'b0;
            tag_reg       <= '0;
            gamma_reg     <= ebbfp_pkg::GAMMA_BASE;
            doff_reg      <= '0;
            dslot_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            hdr_good_reg  <= hdr_good_next;
            finished_reg  <= finished_next;
            held_reg      <= held_next;
            chroma_lo_reg <= chroma_lo_next;
            usable_reg    <= usable_next;
            tag_reg       <= tag_next;
            gamma_reg     <= gamma_next;
            doff_reg      <= doff_next;
            dslot_reg     <= dslot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // record payload, loaded only when a record is produced
    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            kind_reg   <= res_kind;
            value_reg  <= res_value;
            second_reg <= res_second;
            pos_reg    <= res_pos;
            slot_reg   <= res_slot;
        end
    end

    assign records.valid           = out_valid_reg;
    assign records.kind            = kind_reg;
    assign records.value           = value_reg;
    assign records.second_value    = second_reg;
    assign records.position        = pos_reg;
    assign records.descriptor_slot = slot_reg;

endmodule

// ----- hdl/ebbfp_checker.sv -----
// ---------------------------------------------------------------------------
// EDID base block field parser checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`include "edid_base_block_field_parser_defines.svh"

module ebbfp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] kind,
    input logic [3:0] position,
    input logic [1:0] descriptor_slot
);

    `EBBFP_ASSERT_NXT(a_rec_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(position), "record changed while stalled")
    `EBBFP_ASSERT_IMP(a_ready_empty, !out_valid, in_ready, "not ready with empty record register")
    `EBBFP_ASSERT_IMP(a_chroma_pos, out_valid && kind == ebbfp_pkg::KIND_CHROMA, position[3] == 1'b0, "chroma position out of range")
    `EBBFP_ASSERT_IMP(a_slot_zero, out_valid && kind != ebbfp_pkg::KIND_NAME_CHAR && kind != ebbfp_pkg::KIND_SER_CHAR && kind != ebbfp_pkg::KIND_TEXT_CHAR, descriptor_slot == 2'd0, "slot set on non-character record")
    `EBBFP_ASSERT_NXT(a_no_record_idle, !(in_valid && in_ready) && !out_valid, !out_valid, "record without an accepted byte")

endmodule

bind edid_base_block_field_parser ebbfp_checker u_ebbfp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (stream.valid),
    .in_ready        (stream.ready),
    .out_valid       (records.valid),
    .out_ready       (records.ready),
    .kind            (records.kind),
    .position        (records.position),
    .descriptor_slot (records.descriptor_slot)
);

// ----- tb/edid_base_block_field_parser_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// EDID base block field parser test
// Drives directed and random EDID byte streams through the parser under
// several idle and stall patterns, predicts every field record from a
// behavioural copy of the parser and compares each record field by field.
// ---------------------------------------------------------------------------
module edid_base_block_field_parser_test;

    // run shape
    localparam int ITEMS_PER_PHASE = 72;    // with the directed streams, about 550 words
    localparam int LONG_HOLD       = 300;   // receiver hold-off at start of run
    localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no handshake at all
    localparam int DRAIN_CYCLES    = 20;
    localparam int BLOCK_BYTES     = 128;
    localparam int DESC_LEN        = 18;
    localparam logic [7:0] LETTER_BASE = 8'h40;

    typedef enum logic [1:0] {
        PH_STEADY,
        PH_SRC_GAPS,
        PH_SINK_STALLS,
        PH_BOTH
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_word_t;

    typedef struct packed {
        ebbfp_pkg::kind_t kind;
        logic [31:0]      value;
        logic [7:0]       second_value;
        logic [3:0]       position;
        logic [1:0]       slot;
    } field_record_t;

    typedef struct {
        logic [7:0]  idx;
        bit          hdr_ok;
        bit          finished;
        logic [23:0] held;
        logic [15:0] chroma_lo;
        bit          desc_ok;
        logic [7:0]  desc_tag;
        logic [8:0]  gamma;
    } parser_state_t;

    logic clk = 1'b0;
    logic rst_n;

    ebbfp_byte_if stream_ch ();
    ebbfp_rec_if  record_ch ();

    edid_base_block_field_parser i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream_ch),
        .records (record_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    phase_t        phase = PH_STEADY;
    byte_word_t    pending_words[$];
    field_record_t expected_records[$];
    parser_state_t parser;
    logic [7:0]    block_image[BLOCK_BYTES];
    int            sent_items = 0;
    int            mismatches = 0;
    logic          word_taken;

    // -----------------------------------------------------------------------
    // Parser prediction
    // -----------------------------------------------------------------------

    function automatic parser_state_t fresh_state();
        parser_state_t s;
        s.idx       = 8'd0;
        s.hdr_ok    = 1'b1;
        s.finished  = 1'b0;
        s.held      = 24'd0;
        s.chroma_lo = 16'd0;
        s.desc_ok   = 1'b0;
        s.desc_tag  = 8'd0;
        s.gamma     = ebbfp_pkg::GAMMA_BASE;
        return s;
    endfunction

    // Advances the predicted parser by one byte; returns 1 with a record
    // when the byte completes one.
    function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                      output field_record_t rec);
        int         idx;
        int         rel;
        int         off;
        int         k;
        logic [7:0] src;
        logic [7:0] w;
        logic [7:0] h;
        logic [4:0] c1;
        logic [4:0] c2;
        logic [4:0] c3;
        bit         hit;

        idx = parser.idx;
        hit = 1'b0;
        rec = '0;

        // after an error or done record everything is swallowed until final
        if (parser.finished)
        begin
            if (last)
                parser = fresh_state();
            return 1'b0;
        end
        // a short stream overrides whatever this byte would have produced
        if (last && idx < ebbfp_pkg::LAST_INDEX)
        begin
            rec.kind = ebbfp_pkg::KIND_SHORT;
            parser = fresh_state();
            return 1'b1;
        end

        if (idx == ebbfp_pkg::HDR_OFS0)
            parser.hdr_ok = (b == 8'h00);
        else if (idx == ebbfp_pkg::HDR_OFS1)
        begin
            if (!(parser.hdr_ok && b == ebbfp_pkg::HDR_BYTE1))
            begin
                rec.kind = ebbfp_pkg::KIND_HDR_ERR;
                hit = 1'b1;
                parser.finished = 1'b1;
            end
        end
        else if (idx == ebbfp_pkg::VENDOR_OFS ||
                 (idx >= ebbfp_pkg::SERIAL_OFS && idx < ebbfp_pkg::SERIAL_LAST) ||
                 idx == ebbfp_pkg::SIZE_OFS)
            parser.held = {parser.held[15:0], b};
        else if (idx == ebbfp_pkg::VENDOR_OFS2)
        begin
            // three 5-bit letters spread over two bytes, 1 = 'A'
            c1 = parser.held[6:2];
            c2 = {parser.held[1:0], b[7:5]};
            c3 = b[4:0];
            rec.kind  = ebbfp_pkg::KIND_VENDOR;
            rec.value = {8'h00, 8'(LETTER_BASE + c1), 8'(LETTER_BASE + c2),
                         8'(LETTER_BASE + c3)};
            hit = 1'b1;
        end
        else if (idx == ebbfp_pkg::SERIAL_LAST)
        begin
            // little-endian: byte 12 lands in the low byte
            rec.kind  = ebbfp_pkg::KIND_SERIAL;
            rec.value = {b, parser.held[7:0], parser.held[15:8], parser.held[23:16]};
            hit = 1'b1;
        end
        else if (idx == ebbfp_pkg::SIZE_OFS2)
        begin
            w = parser.held[7:0];
            h = b;
            if (w == 8'd0 || h == 8'd0)
            begin
                w = 8'd0;
                h = 8'd0;
            end
            rec.kind         = ebbfp_pkg::KIND_SIZE;
            rec.value        = {24'd0, w};
            rec.second_value = h;
            hit = 1'b1;
        end
        else if (idx == ebbfp_pkg::GAMMA_OFS)
            parser.gamma = (b == ebbfp_pkg::GAMMA_NONE) ? ebbfp_pkg::GAMMA_BASE
                                                        : ebbfp_pkg::GAMMA_BASE + b;
        else if (idx == ebbfp_pkg::CHROMA_LO_OFS)
            parser.chroma_lo[7:0] = b;
        else if (idx == ebbfp_pkg::CHROMA_HI_OFS)
            parser.chroma_lo[15:8] = b;
        else if (idx >= ebbfp_pkg::CHROMA_OFS && idx <= ebbfp_pkg::CHROMA_LAST)
        begin
            // low two bits of each coordinate packed MSB-first, four per byte
            k   = idx - ebbfp_pkg::CHROMA_OFS;
            src = (k < 4) ? parser.chroma_lo[7:0] : parser.chroma_lo[15:8];
            rec.kind     = ebbfp_pkg::KIND_CHROMA;
            rec.value    = {22'd0, b, 2'(src >> (6 - 2 * (k % 4)))};
            rec.position = 4'(k);
            hit = 1'b1;
        end
        else if (idx >= ebbfp_pkg::DESC_FIRST && idx <= ebbfp_pkg::DESC_END)
        begin
            rel = idx - ebbfp_pkg::DESC_FIRST;
            off = rel % DESC_LEN;
            if (off == ebbfp_pkg::DOFF_USABLE)
                parser.desc_ok = (b == 8'h00);
            else if (off == ebbfp_pkg::DOFF_CHECK)
            begin
                if (b != 8'h00)
                    parser.desc_ok = 1'b0;
            end
            else if (off == ebbfp_pkg::DOFF_TAG)
                parser.desc_tag = b;
            else if (off >= ebbfp_pkg::DOFF_CHAR0 && off <= ebbfp_pkg::DOFF_CHARN &&
                     parser.desc_ok)
            begin
                hit = 1'b1;
                if (parser.desc_tag == ebbfp_pkg::TAG_NAME)
                    rec.kind = ebbfp_pkg::KIND_NAME_CHAR;
                else if (parser.desc_tag == ebbfp_pkg::TAG_SERIAL)
                    rec.kind = ebbfp_pkg::KIND_SER_CHAR;
                else if (parser.desc_tag == ebbfp_pkg::TAG_TEXT)
                    rec.kind = ebbfp_pkg::KIND_TEXT_CHAR;
                else
                    hit = 1'b0;
                if (hit)
                begin
                    rec.value    = {24'd0, b};
                    rec.position = 4'(off - ebbfp_pkg::DOFF_CHAR0);
                    rec.slot     = 2'(rel / DESC_LEN);
                end
            end
            // colour-point descriptors may override gamma twice
            if ((off == ebbfp_pkg::DOFF_GAMMA_A || off == ebbfp_pkg::DOFF_GAMMA_B) &&
                parser.desc_ok && parser.desc_tag == ebbfp_pkg::TAG_CPOINT &&
                b != ebbfp_pkg::GAMMA_NONE)
                parser.gamma = ebbfp_pkg::GAMMA_BASE + b;
        end
        else if (idx == ebbfp_pkg::LAST_INDEX)
        begin
            rec.kind  = ebbfp_pkg::KIND_DONE;
            rec.value = {23'd0, parser.gamma};
            hit = 1'b1;
            parser.finished = 1'b1;
        end

        if (!parser.finished && idx < ebbfp_pkg::LAST_INDEX)
            parser.idx = parser.idx + 8'd1;
        if (last)
            parser = fresh_state();
        return hit;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus building
    // -----------------------------------------------------------------------

    task automatic push_word(input logic [7:0] b, input logic last);
        byte_word_t w;
        w.data = b;
        w.last = last;
        pending_words.push_back(w);
        sent_items++;
    endtask

    // Well-formed base block with random content; descriptors lean towards
    // usable ones with the tags the parser reacts to.
    task automatic fill_block();
        int off;
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            block_image[i] = 8'($urandom_range(0, 255));
            if (i == ebbfp_pkg::HDR_OFS0)
                block_image[i] = 8'h00;
            else if (i == ebbfp_pkg::HDR_OFS1)
                block_image[i] = ebbfp_pkg::HDR_BYTE1;
            else if ((i == ebbfp_pkg::SIZE_OFS || i == ebbfp_pkg::SIZE_OFS2) &&
                     $urandom_range(0, 5) == 0)
                block_image[i] = 8'h00;
            else if (i == ebbfp_pkg::GAMMA_OFS && $urandom_range(0, 3) == 0)
                block_image[i] = ebbfp_pkg::GAMMA_NONE;
            else if (i >= ebbfp_pkg::DESC_FIRST && i <= ebbfp_pkg::DESC_END)
            begin
                off = (i - ebbfp_pkg::DESC_FIRST) % DESC_LEN;
                if ((off == ebbfp_pkg::DOFF_USABLE || off == ebbfp_pkg::DOFF_CHECK) &&
                    $urandom_range(0, 7) != 0)
                    block_image[i] = 8'h00;
                else if (off == ebbfp_pkg::DOFF_TAG)
                begin
                    case ($urandom_range(0, 4))
                        0: block_image[i] = ebbfp_pkg::TAG_NAME;
                        1: block_image[i] = ebbfp_pkg::TAG_SERIAL;
                        2: block_image[i] = ebbfp_pkg::TAG_TEXT;
                        3: block_image[i] = ebbfp_pkg::TAG_CPOINT;
                        default: ;
                    endcase
                end
                else if ((off == ebbfp_pkg::DOFF_GAMMA_A || off == ebbfp_pkg::DOFF_GAMMA_B) &&
                         $urandom_range(0, 3) == 0)
                    block_image[i] = ebbfp_pkg::GAMMA_NONE;
            end
        end
    endtask

    // Sends bytes 0..upto of the image, then 'extras' trailing bytes; the
    // final word of the stream carries the last flag.
    task automatic send_block(input int upto, input int extras);
        for (int i = 0; i <= upto; i++)
            push_word(block_image[i], extras == 0 && i == upto);
        for (int j = 1; j <= extras; j++)
            push_word(8'($urandom_range(0, 255)), j == extras);
    endtask

    task automatic directed_streams();
        // bad first header byte, then swallowed bytes up to the final one
        push_word(8'h01, 1'b0);
        push_word(8'hff, 1'b0);
        push_word(8'h55, 1'b0);
        push_word(8'haa, 1'b1);
        // bad second header byte
        push_word(8'h00, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'h00, 1'b1);
        // final on byte 0
        push_word(8'hff, 1'b1);
        // final on a bad second header byte: short wins over header error
        push_word(8'h05, 1'b0);
        push_word(8'h07, 1'b1);
        // short after a good header
        push_word(8'h00, 1'b0);
        push_word(ebbfp_pkg::HDR_BYTE1, 1'b0);
        push_word(8'h80, 1'b1);
        // vendor bytes all ones, then cut short
        push_word(8'h00, 1'b0);
        push_word(ebbfp_pkg::HDR_BYTE1, 1'b0);
        for (int i = 2; i < ebbfp_pkg::VENDOR_OFS; i++)
            push_word(8'($urandom_range(0, 255)), 1'b0);
        push_word(8'hff, 1'b0);
        push_word(8'hff, 1'b0);
        push_word(8'h00, 1'b1);
    endtask

    task automatic random_streams();
        int first;
        int n;
        first = sent_items;
        while (sent_items - first < ITEMS_PER_PHASE)
        begin
            case ($urandom_range(0, 99)) inside
                [0:54]:
                begin
                    // full block, ending on byte 127 or on extension bytes
                    fill_block();
                    send_block(ebbfp_pkg::LAST_INDEX,
                               $urandom_range(0, 1) ? 0 : $urandom_range(1, 4));
                end
                [55:74]:
                begin
                    fill_block();
                    send_block($urandom_range(0, ebbfp_pkg::LAST_INDEX - 1), 0);
                end
                [75:87]:
                begin
                    fill_block();
                    if ($urandom_range(0, 1))
                        block_image[ebbfp_pkg::HDR_OFS0] = 8'($urandom_range(1, 255));
                    else
                        block_image[ebbfp_pkg::HDR_OFS1] = 8'($urandom_range(0, 254));
                    send_block($urandom_range(1, ebbfp_pkg::LAST_INDEX),
                               $urandom_range(0, 2));
                end
                default:
                begin
                    // raw noise with stray final flags
                    n = $urandom_range(1, 12);
                    for (int i = 0; i < n; i++)
                        push_word(8'($urandom_range(0, 255)),
                                  i == n - 1 || $urandom_range(0, 7) == 0);
                end
            endcase
        end
    endtask

    // -----------------------------------------------------------------------
    // Idle patterns per phase
    // -----------------------------------------------------------------------

    function automatic int sender_gap_pct();
        case (phase)
            PH_SRC_GAPS: return 57;
            PH_BOTH:     return 36;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (phase)
            PH_SINK_STALLS: return 57;
            PH_BOTH:        return 36;
            default:        return 0;
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Byte driver: changes on the falling edge, holds the word until taken
    // -----------------------------------------------------------------------
    always @(negedge clk)
    begin
        byte_word_t w;
        if (!rst_n)
        begin
            stream_ch.valid      <= 1'b0;
            stream_ch.edid_byte  <= 8'd0;
            stream_ch.final_byte <= 1'b0;
        end
        else if (!stream_ch.valid || word_taken)
        begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct())
            begin
                w = pending_words.pop_front();
                stream_ch.valid      <= 1'b1;
                stream_ch.edid_byte  <= w.data;
                stream_ch.final_byte <= w.last;
            end
            else
                stream_ch.valid <= 1'b0;
        end
    end

    // -----------------------------------------------------------------------
    // Record receiver: one long hold-off straight after reset so the output
    // register fills and the byte input backs up, then random stalls
    // -----------------------------------------------------------------------
    int hold_cycles = 0;
    bit long_hold_done = 1'b0;

    always @(negedge clk)
    begin
        if (!rst_n)
            record_ch.ready <= 1'b0;
        else if (phase == PH_STEADY && !long_hold_done)
        begin
            record_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= LONG_HOLD - 1)
                long_hold_done <= 1'b1;
        end
        else
            record_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
    end

    // -----------------------------------------------------------------------
    // Monitor: checks records taken at this edge, then predicts from the
    // byte word taken at this edge (its record cannot be out yet)
    // -----------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        field_record_t want;
        field_record_t fresh;
        if (!rst_n)
        begin
            word_taken <= 1'b0;
            parser = fresh_state();
        end
        else
        begin
            word_taken <= stream_ch.valid && stream_ch.ready;
            if (record_ch.valid && record_ch.ready)
            begin
                if (expected_records.size() == 0)
                begin
                    $error("record kind %0d value 0x%0h with nothing expected",
                           record_ch.kind, record_ch.value);
                    mismatches++;
                end
                else
                begin
                    want = expected_records.pop_front();
                    check_field("kind", 32'(want.kind), 32'(record_ch.kind));
                    check_field("value", want.value, record_ch.value);
                    check_field("second_value", 32'(want.second_value),
                                32'(record_ch.second_value));
                    check_field("position", 32'(want.position), 32'(record_ch.position));
                    check_field("descriptor_slot", 32'(want.slot),
                                32'(record_ch.descriptor_slot));
                end
            end
            if (stream_ch.valid && stream_ch.ready)
            begin
                if (parse_byte(stream_ch.edid_byte, stream_ch.final_byte, fresh))
                    expected_records.push_back(fresh);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: any long spell without a handshake on either side is a hang
    // -----------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((stream_ch.valid && stream_ch.ready) || (record_ch.valid && record_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Sequencing: reset, then four phases, each drained before the next
    // -----------------------------------------------------------------------
    initial
    begin
        rst_n                = 1'b0;
        stream_ch.valid      = 1'b0;
        stream_ch.edid_byte  = 8'd0;
        stream_ch.final_byte = 1'b0;
        record_ch.ready      = 1'b0;
        parser               = fresh_state();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_streams();
        for (int p = PH_STEADY; p <= PH_BOTH; p++)
        begin
            @(posedge clk);
            phase = phase_t'(p);
            random_streams();
            @(negedge clk);
            while (pending_words.size() != 0 || stream_ch.valid)
                @(negedge clk);
        end

        while (expected_records.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (expected_records.size() != 0)
            $error("%0d expected records never arrived", expected_records.size());

        if (mismatches == 0 && expected_records.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
